// ===== rtl/fltw_pkg.sv =====
// Shared types, constants and codes for the four-level page-table walker.
`default_nettype none

package fltw_pkg;

    localparam int DEF_LEVELS    = 4;
    localparam int DEF_PHYS_BITS = 52;

    localparam int VA_W      = 48;
    localparam int ENTRY_W   = 64;
    localparam int PA_W      = 52;
    localparam int PEND_W    = 53;
    localparam int RADDR_W   = 64;
    localparam int PLVL_W    = 2;
    localparam int IDX_W     = 9;
    localparam int PAGE_SH   = 12;
    localparam int CFG_W     = 64;

    localparam int PRESENT_BIT = 0;
    localparam int LARGE_BIT   = 7;

    localparam int S_TDATA_W = 112;  // virt_addr + entry_word
    localparam int S_TUSER_W = 2;    // op, read_failed
    localparam int M_TDATA_W = 176;  // 171 bits of fields, padded to bytes
    localparam int M_TUSER_W = 2;    // kind

    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic CFG_DIRECT_MAP_BASE = 1'b0;
    localparam logic CFG_ROOT_TABLE      = 1'b1;

    typedef enum logic [0:0] {
        OP_TRANSLATE = 1'b0,
        OP_ENTRY     = 1'b1
    } op_e;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FAULT = 2'd2,
        KIND_PROTO = 2'd3
    } kind_e;

    // one classified request handed from front to back
    typedef struct packed {
        kind_e             kind;
        logic [PLVL_W-1:0] page_level;
        logic [PA_W-1:0]   addr;   // table entry address (read) or phys (done)
        logic [PA_W-1:0]   span;   // offset mask of the page (done)
    } walk_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/four_level_page_table_walker.sv =====
// An accepted request is written into the queue and then popped into the result register.
// Throughput: one request per cycle while the queue has room; the back stage's 64-bit base add is the widest path.
// A stalled result register fills the two-entry queue; a full queue holds s_tready low.
// Reset (synchronous, aresetn low): walk idle at the top level, queue empty,
// no result pending, both configuration registers zero.
`default_nettype none

module four_level_page_table_walker #(
    parameter int LEVELS    = fltw_pkg::DEF_LEVELS,
    parameter int PHYS_BITS = fltw_pkg::DEF_PHYS_BITS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_index,
    input  wire logic [fltw_pkg::CFG_W-1:0]     cfg_wdata,
    // request stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [fltw_pkg::S_TDATA_W-1:0] s_tdata,  // virt_addr, entry_word
    input  wire logic [fltw_pkg::S_TUSER_W-1:0] s_tuser,  // op, read_failed
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // read_addr, phys_addr, page_limit, page_level, zero pad
    output logic [fltw_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [fltw_pkg::M_TUSER_W-1:0]      m_tuser   // kind
);
    import fltw_pkg::*;

    logic [RADDR_W-1:0]  direct_map_base_reg, direct_map_base_next;
    logic [PA_W-1:0]     root_table_reg, root_table_next;

    logic                push;
    walk_cmd_t           push_cmd;
    logic                queue_full;
    logic                head_valid;
    walk_cmd_t           head_cmd;
    logic                pop;

    kind_e               out_kind;
    logic [RADDR_W-1:0]  out_read_addr;
    logic [PA_W-1:0]     out_phys_addr;
    logic [PEND_W-1:0]   out_page_limit;
    logic [PLVL_W-1:0]   out_page_level;

    always_comb begin
        direct_map_base_next = direct_map_base_reg;
        root_table_next      = root_table_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_DIRECT_MAP_BASE: direct_map_base_next = cfg_wdata;
                CFG_ROOT_TABLE:      root_table_next      = cfg_wdata[PA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direct_map_base_reg <= '0;
            root_table_reg      <= '0;
        end else begin
            direct_map_base_reg <= direct_map_base_next;
            root_table_reg      <= root_table_next;
        end
    end

    fltw_front #(
        .LEVELS    (LEVELS),
        .PHYS_BITS (PHYS_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .root_table  (root_table_reg),
        .in_valid    (s_tvalid),
        .queue_full  (queue_full),
        .op          (s_tuser[0]),
        .virt_addr   (s_tdata[VA_W-1:0]),
        .entry_word  (s_tdata[VA_W+ENTRY_W-1:VA_W]),
        .read_failed (s_tuser[1]),
        .in_ready    (s_tready),
        .push        (push),
        .cmd         (push_cmd)
    );

    fltw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    fltw_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .direct_map_base (direct_map_base_reg),
        .head_valid      (head_valid),
        .head_cmd        (head_cmd),
        .pop             (pop),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_kind        (out_kind),
        .out_read_addr   (out_read_addr),
        .out_phys_addr   (out_phys_addr),
        .out_page_limit  (out_page_limit),
        .out_page_level  (out_page_level)
    );

    assign m_tdata = {5'b0, out_page_level, out_page_limit, out_phys_addr, out_read_addr};
    assign m_tuser = out_kind;

endmodule

`default_nettype wire

// ===== rtl/fltw_front.sv =====
// Front end: accepts requests, tracks the walk state and classifies each step.
`default_nettype none

module fltw_front #(
    parameter int LEVELS    = fltw_pkg::DEF_LEVELS,
    parameter int PHYS_BITS = fltw_pkg::DEF_PHYS_BITS
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [fltw_pkg::PA_W-1:0]    root_table,
    input  wire logic                         in_valid,
    input  wire logic                         queue_full,
    input  wire logic                         op,
    input  wire logic [fltw_pkg::VA_W-1:0]    virt_addr,
    input  wire logic [fltw_pkg::ENTRY_W-1:0] entry_word,
    input  wire logic                         read_failed,
    output logic                              in_ready,
    output logic                              push,
    output fltw_pkg::walk_cmd_t               cmd
);
    import fltw_pkg::*;

    localparam int LVL_W = $clog2(LEVELS);
    localparam logic [LVL_W-1:0] TOP_LEVEL = LVL_W'(LEVELS - 1);
    localparam logic [63:0] PHYS_MASK64 = (64'(1) << PHYS_BITS) - 64'd1;
    localparam logic [PA_W-1:0] PHYS_MASK  = PHYS_MASK64[PA_W-1:0];
    localparam logic [PA_W-1:0] TABLE_MASK = PHYS_MASK & ~PA_W'(12'hfff);

    logic                  walk_busy_reg, walk_busy_next;
    logic [VA_W-1:0]       pending_vaddr_reg, pending_vaddr_next;
    logic [LVL_W-1:0]      current_level_reg, current_level_next;
    logic [PA_W-1:0]       current_table_reg, current_table_next;

    logic                  accept;
    logic                  emit_read;
    logic [LVL_W-1:0]      rd_level;
    logic [VA_W-1:0]       rd_vaddr;
    logic [63:0]           rd_shifted;
    logic [IDX_W-1:0]      rd_idx;
    logic [63:0]           low_mask;
    logic [63:0]           phys64;

    function automatic logic [6:0] level_shift(input logic [LVL_W-1:0] lvl);
        return 7'(PAGE_SH + IDX_W * int'(lvl));
    endfunction

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept;

    // index slice and page offset mask
    assign rd_shifted = 64'(rd_vaddr) >> level_shift(rd_level);
    assign rd_idx     = rd_shifted[IDX_W-1:0];
    assign low_mask   = (64'(1) << level_shift(current_level_reg)) - 64'd1;
    assign phys64     = (entry_word & ~low_mask) | (64'(pending_vaddr_reg) & low_mask);

    always_comb begin
        walk_busy_next     = walk_busy_reg;
        pending_vaddr_next = pending_vaddr_reg;
        current_level_next = current_level_reg;
        current_table_next = current_table_reg;
        emit_read          = 1'b0;
        rd_level           = current_level_reg;
        rd_vaddr           = pending_vaddr_reg;
        cmd.kind           = KIND_PROTO;
        cmd.page_level     = '0;
        cmd.addr           = '0;
        cmd.span           = '0;

        if (accept) begin
            if (op_e'(op) == OP_TRANSLATE) begin
                if (!walk_busy_reg) begin
                    walk_busy_next     = 1'b1;
                    pending_vaddr_next = virt_addr;
                    current_level_next = TOP_LEVEL;
                    current_table_next = root_table & TABLE_MASK;
                    emit_read          = 1'b1;
                    rd_level           = TOP_LEVEL;
                    rd_vaddr           = virt_addr;
                end
            end else if (walk_busy_reg) begin
                if (read_failed || !entry_word[PRESENT_BIT]) begin
                    cmd.kind           = KIND_FAULT;
                    cmd.page_level     = PLVL_W'(current_level_reg);
                    walk_busy_next     = 1'b0;
                    current_level_next = TOP_LEVEL;
                end else if (entry_word[LARGE_BIT] || current_level_reg == '0) begin
                    cmd.kind           = KIND_DONE;
                    cmd.page_level     = PLVL_W'(current_level_reg);
                    cmd.addr           = phys64[PA_W-1:0] & PHYS_MASK;
                    cmd.span           = low_mask[PA_W-1:0] & PHYS_MASK;
                    walk_busy_next     = 1'b0;
                    current_level_next = TOP_LEVEL;
                end else begin
                    current_table_next = entry_word[PA_W-1:0] & TABLE_MASK;
                    current_level_next = current_level_reg - LVL_W'(1);
                    emit_read          = 1'b1;
                    rd_level           = current_level_reg - LVL_W'(1);
                end
            end
        end

        if (emit_read) begin
            cmd.kind       = KIND_READ;
            cmd.page_level = PLVL_W'(rd_level);
            // table is 4 KiB aligned, so the entry offset is simply or-ed in
            cmd.addr       = current_table_next | (PA_W'(rd_idx) << 3);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_busy_reg     <= 1'b0;
            pending_vaddr_reg <= '0;
            current_level_reg <= TOP_LEVEL;
            current_table_reg <= '0;
        end else begin
            walk_busy_reg     <= walk_busy_next;
            pending_vaddr_reg <= pending_vaddr_next;
            current_level_reg <= current_level_next;
            current_table_reg <= current_table_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fltw_queue.sv =====
// Two-entry request queue between the front end and the back end.
`default_nettype none

module fltw_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  fltw_pkg::walk_cmd_t      push_cmd,
    input  wire logic                pop,
    output logic                     full,
    output logic                     head_valid,
    output fltw_pkg::walk_cmd_t      head_cmd
);
    import fltw_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    walk_cmd_t           store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = store_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fltw_back.sv =====
// Back end: forms read addresses and page bounds, holds the result register.
`default_nettype none

module fltw_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [fltw_pkg::RADDR_W-1:0] direct_map_base,
    input  wire logic                         head_valid,
    input  fltw_pkg::walk_cmd_t               head_cmd,
    output logic                              pop,
    input  wire logic                         out_ready,
    output logic                              out_valid,
    output fltw_pkg::kind_e                   out_kind,
    output logic [fltw_pkg::RADDR_W-1:0]      out_read_addr,
    output logic [fltw_pkg::PA_W-1:0]         out_phys_addr,
    output logic [fltw_pkg::PEND_W-1:0]       out_page_limit,
    output logic [fltw_pkg::PLVL_W-1:0]       out_page_level
);
    import fltw_pkg::*;

    logic                  m_valid_reg, m_valid_next;
    kind_e                 kind_reg, kind_next;
    logic [RADDR_W-1:0]    read_addr_reg, read_addr_next;
    logic [PA_W-1:0]       phys_addr_reg, phys_addr_next;
    logic [PEND_W-1:0]     page_limit_reg, page_limit_next;
    logic [PLVL_W-1:0]     page_level_reg, page_level_next;

    assign pop = head_valid && (!m_valid_reg || out_ready);

    always_comb begin
        m_valid_next    = m_valid_reg;
        kind_next       = kind_reg;
        read_addr_next  = read_addr_reg;
        phys_addr_next  = phys_addr_reg;
        page_limit_next = page_limit_reg;
        page_level_next = page_level_reg;
        if (pop) begin
            m_valid_next    = 1'b1;
            kind_next       = head_cmd.kind;
            page_level_next = head_cmd.page_level;
            read_addr_next  = '0;
            phys_addr_next  = '0;
            page_limit_next = '0;
            unique case (head_cmd.kind)
                KIND_READ: begin
                    read_addr_next = direct_map_base + RADDR_W'(head_cmd.addr);
                end
                KIND_DONE: begin
                    phys_addr_next  = head_cmd.addr;
                    page_limit_next = PEND_W'(head_cmd.addr | head_cmd.span) + PEND_W'(1);
                end
                KIND_FAULT: begin
                end
                KIND_PROTO: begin
                    page_level_next = '0;
                end
                default: begin
                end
            endcase
        end else if (out_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        read_addr_reg  <= read_addr_next;
        phys_addr_reg  <= phys_addr_next;
        page_limit_reg <= page_limit_next;
        page_level_reg <= page_level_next;
    end

    assign out_valid      = m_valid_reg;
    assign out_kind       = kind_reg;
    assign out_read_addr  = read_addr_reg;
    assign out_phys_addr  = phys_addr_reg;
    assign out_page_limit = page_limit_reg;
    assign out_page_level = page_level_reg;

endmodule

`default_nettype wire
